>>> design/sfa_pkg.sv
`timescale 1ns / 1ps

package sfa_pkg;

    // Default fixed-point layout.
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 8'd1;

    // Iteration counter: the square root takes the most passes.
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

    // Datapath micro-operations.
    typedef enum logic [4:0] {
        U_NOP,
        U_LOAD,
        U_MUL_AX,
        U_MUL_AZ,
        U_MUL_RR,
        U_SQ_INIT,
        U_SQ_STEP,
        U_DQ_INIT,
        U_DIV_STEP,
        U_MUL_XQ,
        U_DT_INIT,
        U_ACC_X,
        U_ACC_Z,
        U_SCL_HI_X,
        U_SCL_LO_X,
        U_SCL_FIN_X,
        U_SCL_HI_Z,
        U_SCL_LO_Z,
        U_SCL_FIN_Z,
        U_EMIT
    } uop_t;

    // Jump conditions of the sequencer.
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_WAIT,
        C_SKIP,
        C_RANGE,
        C_DBAD,
        C_LOOP,
        C_NOTLAST,
        C_OUTBUSY
    } cond_t;

    localparam int UPC_W      = 5;
    localparam int UCODE_LEN  = 24;
    typedef logic [UPC_W-1:0] upc_t;

    // Named addresses of the program.
    localparam upc_t A_LOAD    = 5'd0;
    localparam upc_t A_SQ_LOOP = 5'd5;
    localparam upc_t A_DQ_LOOP = 5'd7;
    localparam upc_t A_DX_LOOP = 5'd10;
    localparam upc_t A_DZ_LOOP = 5'd13;
    localparam upc_t A_FIN     = 5'd15;
    localparam upc_t A_EMIT    = 5'd22;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  target;
    } ctl_t;

    // Status flags from the datapath that the sequencer branches on.
    typedef struct packed {
        logic skip_item;
        logic range_fail;
        logic d_bad;
        logic loop_more;
        logic last;
    } dp_stat_t;

    // The program. A step jumps to its target when its condition holds,
    // otherwise it falls through to the next address.
    localparam ctl_t UCODE [UCODE_LEN] = '{
        '{U_LOAD,      C_WAIT,    A_LOAD},
        '{U_MUL_AX,    C_SKIP,    A_FIN},
        '{U_MUL_AZ,    C_NEXT,    A_LOAD},
        '{U_MUL_RR,    C_NEXT,    A_LOAD},
        '{U_SQ_INIT,   C_RANGE,   A_FIN},
        '{U_SQ_STEP,   C_LOOP,    A_SQ_LOOP},
        '{U_DQ_INIT,   C_DBAD,    A_FIN},
        '{U_DIV_STEP,  C_LOOP,    A_DQ_LOOP},
        '{U_MUL_XQ,    C_NEXT,    A_LOAD},
        '{U_DT_INIT,   C_NEXT,    A_LOAD},
        '{U_DIV_STEP,  C_LOOP,    A_DX_LOOP},
        '{U_ACC_X,     C_NEXT,    A_LOAD},
        '{U_DT_INIT,   C_NEXT,    A_LOAD},
        '{U_DIV_STEP,  C_LOOP,    A_DZ_LOOP},
        '{U_ACC_Z,     C_NEXT,    A_LOAD},
        '{U_NOP,       C_NOTLAST, A_LOAD},
        '{U_SCL_HI_X,  C_NEXT,    A_LOAD},
        '{U_SCL_LO_X,  C_NEXT,    A_LOAD},
        '{U_SCL_FIN_X, C_NEXT,    A_LOAD},
        '{U_SCL_HI_Z,  C_NEXT,    A_LOAD},
        '{U_SCL_LO_Z,  C_NEXT,    A_LOAD},
        '{U_SCL_FIN_Z, C_NEXT,    A_LOAD},
        '{U_EMIT,      C_OUTBUSY, A_EMIT},
        '{U_NOP,       C_ALWAYS,  A_LOAD}
    };

endpackage

>>> design/sfa_seq.sv
`timescale 1ns / 1ps

module sfa_seq import sfa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  dp_stat_t dp_stat,
    input  logic     in_valid,
    input  logic     out_busy,
    output uop_t     op
);

    upc_t pc_reg;
    upc_t pc_next;
    ctl_t ctl;
    logic take;

    assign ctl = UCODE[pc_reg];
    assign op  = ctl.op;

    always_comb begin
        unique case (ctl.cond)
            C_NEXT:    take = 1'b0;
            C_ALWAYS:  take = 1'b1;
            C_WAIT:    take = !in_valid;
            C_SKIP:    take = dp_stat.skip_item;
            C_RANGE:   take = dp_stat.range_fail;
            C_DBAD:    take = dp_stat.d_bad;
            C_LOOP:    take = dp_stat.loop_more;
            C_NOTLAST: take = !dp_stat.last;
            C_OUTBUSY: take = out_busy;
            default:   take = 1'b0;
        endcase
        pc_next = take ? ctl.target : pc_reg + UPC_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= A_LOAD;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> design/sfa_dp.sv
`timescale 1ns / 1ps

module sfa_dp import sfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  uop_t               op,
    input  logic               in_fire,
    input  logic               emit_fire,
    input  logic signed [31:0] self_x,
    input  logic signed [31:0] self_z,
    input  logic [7:0]         self_kind,
    input  logic signed [31:0] other_x,
    input  logic signed [31:0] other_z,
    input  logic [7:0]         other_kind,
    input  logic               other_dead,
    input  logic               is_self,
    input  logic               last,
    input  logic [31:0]        radius,
    input  logic [31:0]        strength,
    output dp_stat_t           dp_stat,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_z
);

    localparam int QW        = FRAC_BITS + 1;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int SW        = ACC_WIDTH + 1;
    localparam logic [31:0] EPS_RAW =
        32'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

    logic                 counted_reg, counted_next;
    logic                 last_reg, last_next;
    logic                 dxn_reg, dxn_next;
    logic                 dzn_reg, dzn_next;
    logic [31:0]          ax_reg, ax_next;
    logic [31:0]          az_reg, az_next;
    logic [63:0]          prod_reg, prod_next;
    logic [63:0]          sq_reg, sq_next;
    logic [64:0]          dsq_reg, dsq_next;
    logic [63:0]          rad_reg, rad_next;
    logic [33:0]          srem_reg, srem_next;
    logic [31:0]          root_reg, root_next;
    logic [31:0]          drem_reg, drem_next;
    logic [QW-1:0]        nsh_reg, nsh_next;
    logic [31:0]          den_reg, den_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ACC_WIDTH-1:0] sumx_reg, sumx_next;
    logic [ACC_WIDTH-1:0] sumz_reg, sumz_next;
    logic [63:0]          ph_reg, ph_next;
    logic [31:0]          fx_reg, fx_next;
    logic [31:0]          fz_reg, fz_next;

    logic [32:0] dx, dz;
    logic [31:0] mul_a, mul_b;
    logic        mul_en;
    logic [35:0] st, trial;
    logic        sge;
    logic [32:0] dt, dsub;
    logic        dge;
    logic [31:0] diff;
    logic [63:0] magx, magz;

    function automatic logic [63:0] mag64(input logic [ACC_WIDTH-1:0] v);
        logic [ACC_WIDTH-1:0] m;
        m = v[ACC_WIDTH-1] ? ACC_WIDTH'(~v + 1'b1) : v;
        return 64'(m);
    endfunction

    // Saturating add of a sign-magnitude term to an accumulator.
    function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                     input logic neg,
                                                     input logic [QW-1:0] m);
        logic [SW-1:0] ext, t, s;
        ext = {a[ACC_WIDTH-1], a};
        t   = SW'(m);
        s   = neg ? ext - t : ext + t;
        if (s[SW-1] != s[SW-2]) begin
            return s[SW-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        return s[ACC_WIDTH-1:0];
    endfunction

    // Combine the two partial products, drop the fraction and saturate.
    function automatic logic [31:0] scale(input logic [63:0] hi_p,
                                          input logic [63:0] lo_p,
                                          input logic neg);
        logic [95:0] full, sh, limit;
        logic [31:0] res;
        full  = {hi_p, 32'd0} + {32'd0, lo_p};
        sh    = full >> FRAC_BITS;
        limit = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
        res   = (sh > limit) ? limit[31:0] : sh[31:0];
        return neg ? 32'd0 - res : res;
    endfunction

    assign dx   = {self_x[31], self_x} - {other_x[31], other_x};
    assign dz   = {self_z[31], self_z} - {other_z[31], other_z};
    assign magx = mag64(sumx_reg);
    assign magz = mag64(sumz_reg);
    assign diff = radius - root_reg;

    // One square-root digit per pass.
    assign trial = {2'b00, root_reg, 2'b01};
    assign st    = {srem_reg, rad_reg[63:62]};
    assign sge   = st >= trial;

    // One quotient bit per pass; quotient bits shift in behind the numerator.
    assign dt   = {drem_reg, nsh_reg[QW-1]};
    assign dsub = dt - {1'b0, den_reg};
    assign dge  = dt >= {1'b0, den_reg};

    always_comb begin
        mul_en = 1'b1;
        mul_a  = ax_reg;
        mul_b  = ax_reg;
        unique case (op)
            U_MUL_AX:   begin mul_a = ax_reg;        mul_b = ax_reg; end
            U_MUL_AZ:   begin mul_a = az_reg;        mul_b = az_reg; end
            U_MUL_RR:   begin mul_a = radius;        mul_b = radius; end
            U_MUL_XQ:   begin mul_a = ax_reg;        mul_b = 32'(nsh_reg); end
            U_ACC_X:    begin mul_a = az_reg;        mul_b = 32'(q_reg); end
            U_SCL_HI_X: begin mul_a = magx[63:32];   mul_b = strength; end
            U_SCL_LO_X: begin mul_a = magx[31:0];    mul_b = strength; end
            U_SCL_HI_Z: begin mul_a = magz[63:32];   mul_b = strength; end
            U_SCL_LO_Z: begin mul_a = magz[31:0];    mul_b = strength; end
            default:    mul_en = 1'b0;
        endcase
    end

    always_comb begin
        counted_next = counted_reg;
        last_next    = last_reg;
        dxn_next     = dxn_reg;
        dzn_next     = dzn_reg;
        ax_next      = ax_reg;
        az_next      = az_reg;
        prod_next    = mul_en ? mul_a * mul_b : prod_reg;
        sq_next      = sq_reg;
        dsq_next     = dsq_reg;
        rad_next     = rad_reg;
        srem_next    = srem_reg;
        root_next    = root_reg;
        drem_next    = drem_reg;
        nsh_next     = nsh_reg;
        den_next     = den_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        sumx_next    = sumx_reg;
        sumz_next    = sumz_reg;
        ph_next      = ph_reg;
        fx_next      = fx_reg;
        fz_next      = fz_reg;
        unique case (op)
            U_LOAD: begin
                if (in_fire) begin
                    counted_next = !other_dead && !is_self && (self_kind == other_kind);
                    last_next    = last;
                    dxn_next     = dx[32];
                    dzn_next     = dz[32];
                    ax_next      = dx[32] ? 32'(33'd0 - dx) : dx[31:0];
                    az_next      = dz[32] ? 32'(33'd0 - dz) : dz[31:0];
                end
            end
            U_MUL_AZ: sq_next = prod_reg;
            U_MUL_RR: dsq_next = {1'b0, sq_reg} + {1'b0, prod_reg};
            U_SQ_INIT: begin
                rad_next  = dsq_reg[63:0];
                srem_next = '0;
                root_next = '0;
                cnt_next  = CNT_W'(SQRT_STEPS);
            end
            U_SQ_STEP: begin
                rad_next  = {rad_reg[61:0], 2'b00};
                srem_next = sge ? 34'(st - trial) : st[33:0];
                root_next = {root_reg[30:0], sge};
                cnt_next  = cnt_reg - 1'b1;
            end
            U_DQ_INIT: begin
                drem_next = {1'b0, diff[31:1]};
                nsh_next  = {diff[0], {FRAC_BITS{1'b0}}};
                den_next  = radius;
                cnt_next  = CNT_W'(DIV_STEPS);
            end
            U_DIV_STEP: begin
                drem_next = dge ? dsub[31:0] : dt[31:0];
                nsh_next  = {nsh_reg[QW-2:0], dge};
                cnt_next  = cnt_reg - 1'b1;
            end
            U_MUL_XQ: q_next = nsh_reg;
            U_DT_INIT: begin
                drem_next = prod_reg[FRAC_BITS+32:FRAC_BITS+1];
                nsh_next  = prod_reg[FRAC_BITS:0];
                den_next  = root_reg;
                cnt_next  = CNT_W'(DIV_STEPS);
            end
            U_ACC_X: sumx_next = sat_add(sumx_reg, dxn_reg, nsh_reg);
            U_ACC_Z: sumz_next = sat_add(sumz_reg, dzn_reg, nsh_reg);
            U_SCL_LO_X, U_SCL_LO_Z: ph_next = prod_reg;
            U_SCL_FIN_X: fx_next = scale(ph_reg, prod_reg, sumx_reg[ACC_WIDTH-1]);
            U_SCL_FIN_Z: fz_next = scale(ph_reg, prod_reg, sumz_reg[ACC_WIDTH-1]);
            U_EMIT: begin
                if (emit_fire) begin
                    sumx_next = '0;
                    sumz_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sumx_reg <= '0;
            sumz_reg <= '0;
        end else begin
            sumx_reg <= sumx_next;
            sumz_reg <= sumz_next;
        end
    end

    always_ff @(posedge aclk) begin
        counted_reg <= counted_next;
        last_reg    <= last_next;
        dxn_reg     <= dxn_next;
        dzn_reg     <= dzn_next;
        ax_reg      <= ax_next;
        az_reg      <= az_next;
        prod_reg    <= prod_next;
        sq_reg      <= sq_next;
        dsq_reg     <= dsq_next;
        rad_reg     <= rad_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
        drem_reg    <= drem_next;
        nsh_reg     <= nsh_next;
        den_reg     <= den_next;
        q_reg       <= q_next;
        cnt_reg     <= cnt_next;
        ph_reg      <= ph_next;
        fx_reg      <= fx_next;
        fz_reg      <= fz_next;
    end

    assign dp_stat.skip_item  = !counted_reg;
    assign dp_stat.range_fail = dsq_reg[64] || (dsq_reg[63:0] > prod_reg);
    assign dp_stat.d_bad      = (root_reg == 32'd0) || (root_reg < EPS_RAW);
    assign dp_stat.loop_more  = cnt_reg != CNT_W'(1);
    assign dp_stat.last       = last_reg;

    assign force_x = fx_reg;
    assign force_z = fz_reg;

endmodule

>>> design/separation_force_accumulator_unit.sv
`timescale 1ns / 1ps

// Separation steering accumulator. Each input item carries the agent's own
// position and kind together with one neighbour; the neighbour adds to the
// running force only when it is alive, is not the agent itself and has the
// same kind. A counted neighbour inside the radius and not closer than about
// 1e-4 world units adds offset * (1 - d/radius) / d to saturating x and z
// sums. The item flagged last also produces one result item: both sums
// scaled by strength, truncated toward zero and saturated to 32 bits, after
// which the sums restart from zero. A small microcoded sequencer drives one
// shared 32x32 multiplier, a one-digit-per-cycle square root and a
// one-bit-per-cycle divider. For a counted neighbour inside the radius the
// square root runs 32 passes and each of three divisions runs FRAC_BITS+1
// passes (16 fraction bits by default). An item that is not counted skips the
// arithmetic, one outside the radius stops after the range check, and a last
// item then runs the final scaling. The result sits in an output register,
// so the next item is accepted while it waits to be taken.
// Registers: index 0 is radius, index 1 is strength; other indexes are
// ignored. Write them only while the block is idle.

module separation_force_accumulator_unit import sfa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_self_x,
    input  logic signed [31:0]   s_self_z,
    input  logic [7:0]           s_self_kind,
    input  logic signed [31:0]   s_other_x,
    input  logic signed [31:0]   s_other_z,
    input  logic [7:0]           s_other_kind,
    input  logic                 s_other_dead,
    input  logic                 s_is_self,
    input  logic                 s_last,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_force_x,
    output logic signed [31:0]   m_force_z,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    uop_t     op;
    dp_stat_t dp_stat;
    logic     in_fire;
    logic     out_busy;
    logic     emit_fire;

    logic [31:0] radius_reg, radius_next;
    logic [31:0] strength_reg, strength_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] fx_out_reg, fx_out_next;
    logic [31:0] fz_out_reg, fz_out_next;
    logic signed [31:0] dp_force_x, dp_force_z;

    // The input side is open only on the load step of the program.
    assign s_ready   = (op == U_LOAD);
    assign in_fire   = s_valid && s_ready;

    // A result may overwrite the output register once the old one is taken.
    assign out_busy  = m_valid_reg && !m_ready;
    assign emit_fire = (op == U_EMIT) && !out_busy;

    // Registers can be written at any cycle.
    assign cfg_ready = 1'b1;

    sfa_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dp_stat  (dp_stat),
        .in_valid (s_valid),
        .out_busy (out_busy),
        .op       (op)
    );

    sfa_dp #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .in_fire    (in_fire),
        .emit_fire  (emit_fire),
        .self_x     (s_self_x),
        .self_z     (s_self_z),
        .self_kind  (s_self_kind),
        .other_x    (s_other_x),
        .other_z    (s_other_z),
        .other_kind (s_other_kind),
        .other_dead (s_other_dead),
        .is_self    (s_is_self),
        .last       (s_last),
        .radius     (radius_reg),
        .strength   (strength_reg),
        .dp_stat    (dp_stat),
        .force_x    (dp_force_x),
        .force_z    (dp_force_z)
    );

    // Configuration writes.
    always_comb begin
        radius_next   = radius_reg;
        strength_next = strength_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RADIUS:   radius_next   = cfg_data;
                REG_STRENGTH: strength_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Output register: a new result is loaded in the same cycle the previous
    // one is taken, so there is no bubble between back-to-back results.
    always_comb begin
        m_valid_next = m_valid_reg;
        fx_out_next  = fx_out_reg;
        fz_out_next  = fz_out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit_fire) begin
            m_valid_next = 1'b1;
            fx_out_next  = dp_force_x;
            fz_out_next  = dp_force_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 32'd131072;
            strength_reg <= 32'd65536;
            m_valid_reg  <= 1'b0;
        end else begin
            radius_reg   <= radius_next;
            strength_reg <= strength_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fx_out_reg <= fx_out_next;
        fz_out_reg <= fz_out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_force_x = fx_out_reg;
    assign m_force_z = fz_out_reg;

endmodule

>>> design/sfa_checker.sv
`timescale 1ns / 1ps

module sfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_force_x,
    input logic [31:0] m_force_z
);

    // After an accept the program moves past the load step, so the input closes.
    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on two consecutive cycles");

    // A non-last item accepted while no result is held does not make a result appear right after it.
    a_no_result_without_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last && !m_valid) |=> !m_valid)
        else $error("result appeared right after a non-last item");

    a_out_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before it was taken");

    a_out_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_force_x) && $stable(m_force_z)))
        else $error("result changed while stalled");

endmodule

bind separation_force_accumulator_unit sfa_checker u_sfa_checker (.*);
